// File: rtl/core/spdsq_pkg.sv
// spdsq_pkg: widths, item types and small helper functions of the segment pair
// distance unit. It depends on nothing and is imported by every module of the block.
package spdsq_pkg;

   localparam int COORD_W      = 32;
   localparam int COORD_FRAC   = 16;
   localparam int PARAM_FRAC   = 16;
   localparam int PARAM_W      = 18;
   localparam int QUOT_W       = PARAM_W + 1;
   localparam int DIST_W       = 63;
   localparam int THRESH_W     = 32;
   localparam int THRESH_RESET = 4295;

   localparam int DELTA_W   = COORD_W + 1;
   localparam int UU_W      = 2 * COORD_W;
   localparam int UW_W      = 2 * COORD_W + 1;
   localparam int DE_W      = 2 * COORD_W + 2;
   localparam int SUM_W     = DE_W + 1;
   localparam int NUM_W     = 4 * COORD_W + 2;
   localparam int DET_W     = 4 * COORD_W - 1;
   localparam int THR_SHIFT = 4 * COORD_FRAC - THRESH_W;

   localparam int MUL_W = DE_W;
   localparam int LO_W  = 32;
   localparam int HI_W  = MUL_W - LO_W;

   localparam int DIV_STEPS = PARAM_FRAC + 1;
   localparam int REM_W     = NUM_W + DIV_STEPS;
   localparam int DIV_LAT   = DIV_STEPS + 2;

   localparam int PROD_W  = PARAM_W + COORD_W;
   localparam int DX_W    = DELTA_W + PARAM_FRAC + 2;
   localparam int SQ_W    = 2 * DX_W;
   localparam int SAT_BIT = DIST_W + 2 * COORD_FRAC;

   localparam int IN_DATA_W  = 8 * COORD_W;
   localparam int OUT_BITS   = DIST_W + 2 * PARAM_W;
   localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int CSR_IDX_W = CSR_AW - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_IDX = '0;

   localparam logic signed [QUOT_W-1:0] Q_PONE = QUOT_W'(1 << PARAM_FRAC);

   typedef struct packed {
      logic signed [COORD_W-1:0] p1x;
      logic signed [COORD_W-1:0] p1y;
      logic signed [COORD_W-1:0] u1x;
      logic signed [COORD_W-1:0] u1y;
      logic signed [COORD_W-1:0] p2x;
      logic signed [COORD_W-1:0] p2y;
      logic signed [COORD_W-1:0] u2x;
      logic signed [COORD_W-1:0] u2y;
   } coord_set_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] u1x;
      logic signed [COORD_W-1:0] u1y;
      logic signed [COORD_W-1:0] u2x;
      logic signed [COORD_W-1:0] u2y;
      logic signed [DELTA_W-1:0] wx;
      logic signed [DELTA_W-1:0] wy;
   } geom_type;

   typedef struct packed {
      logic     parallel;
      logic     d_neg;
      geom_type geom;
   } side_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] s_num;
      logic signed [NUM_W-1:0] t_num;
      logic signed [SUM_W-1:0] tp_num;
      logic signed [SUM_W-1:0] tm_num;
      logic signed [SUM_W-1:0] sp_num;
      logic signed [SUM_W-1:0] sm_num;
      logic [DET_W-1:0]        det;
      logic [UU_W-1:0]         a;
      logic [UU_W-1:0]         c;
   } div_req_type;

   typedef struct packed {
      logic signed [QUOT_W-1:0] s_free;
      logic signed [QUOT_W-1:0] t_free;
      logic signed [QUOT_W-1:0] t_plus;
      logic signed [QUOT_W-1:0] t_minus;
      logic signed [QUOT_W-1:0] s_plus;
      logic signed [QUOT_W-1:0] s_minus;
   } quot_type;

   typedef struct packed {
      logic signed [PARAM_W-1:0] param_second;
      logic signed [PARAM_W-1:0] param_first;
      logic [DIST_W-1:0]         distance_squared;
   } result_type;

   typedef struct packed {
      logic [2*LO_W-1:0]           ll;
      logic signed [LO_W+HI_W:0]   lh;
      logic signed [LO_W+HI_W:0]   hl;
      logic signed [2*HI_W-1:0]    hh;
   } part_type;

   // The four partial products of a wide signed product, split at bit LO_W.
   function automatic part_type split_mul(input logic signed [MUL_W-1:0] x,
                                          input logic signed [MUL_W-1:0] y);
      part_type p;
      p.ll = x[LO_W-1:0] * y[LO_W-1:0];
      p.lh = $signed({1'b0, x[LO_W-1:0]}) * $signed(y[MUL_W-1:LO_W]);
      p.hl = $signed(x[MUL_W-1:LO_W]) * $signed({1'b0, y[LO_W-1:0]});
      p.hh = $signed(x[MUL_W-1:LO_W]) * $signed(y[MUL_W-1:LO_W]);
      return p;
   endfunction

   function automatic logic signed [NUM_W-1:0] join_parts(input part_type p);
      logic signed [NUM_W-1:0] mid;
      mid = NUM_W'(p.lh) + NUM_W'(p.hl);
      return (NUM_W'(p.hh) <<< (2 * LO_W)) + (mid <<< LO_W) + $signed(NUM_W'(p.ll));
   endfunction

   function automatic logic out_of_range(input logic signed [QUOT_W-1:0] q);
      return (q > Q_PONE) || (q < -Q_PONE);
   endfunction

   function automatic logic signed [QUOT_W-1:0] clamp_unit(
      input logic signed [QUOT_W-1:0] q);
      logic signed [QUOT_W-1:0] r;
      r = q;
      if (q > Q_PONE) r = Q_PONE;
      if (q < -Q_PONE) r = -Q_PONE;
      return r;
   endfunction

endpackage

// File: rtl/core/spdsq_dot.sv
// spdsq_dot: six pipeline stages that form the offset, the dot products, the
// determinant and all division numerators. Depends on spdsq_pkg.
module spdsq_dot (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  spdsq_pkg::coord_set_type       in_coord,
   input  logic [spdsq_pkg::THRESH_W-1:0] threshold,
   output logic                           out_valid,
   output spdsq_pkg::div_req_type         out_req,
   output spdsq_pkg::side_type            out_side
);
   import spdsq_pkg::*;

   localparam int NSTAGE = 6;

   logic [NSTAGE-1:0] valid_ff, valid_in;

   geom_type g1_ff, g1_in, g2_ff, g3_ff, g4_ff, g5_ff;

   logic signed [UU_W-1:0] uu_ff [6];
   logic signed [UU_W-1:0] uu_in [6];
   logic signed [UW_W-1:0] uw_ff [4];
   logic signed [UW_W-1:0] uw_in [4];

   logic [UU_W-1:0]        a3_ff, a3_in, c3_ff, c3_in, a4_ff, c4_ff, a5_ff, c5_ff;
   logic signed [UW_W-1:0] b3_ff, b3_in;
   logic signed [DE_W-1:0] d3_ff, d3_in, e3_ff, e3_in;
   logic                   dneg4_ff, dneg5_ff;

   part_type acp_ff, acp_in, bbp_ff, bbp_in, bep_ff, bep_in;
   part_type cdp_ff, cdp_in, aep_ff, aep_in, bdp_ff, bdp_in;

   logic signed [NUM_W-1:0] ac_ff, ac_in, bb_ff, bb_in, be_ff, be_in;
   logic signed [NUM_W-1:0] cd_ff, cd_in, ae_ff, ae_in, bd_ff, bd_in;
   logic signed [SUM_W-1:0] tp_ff, tp_in, tm_ff, tm_in, sp_ff, sp_in, sm_ff, sm_in;
   logic signed [SUM_W-1:0] tp5_ff, tm5_ff, sp5_ff, sm5_ff;

   div_req_type req6_ff, req6_in;
   side_type    side6_ff, side6_in;
   logic signed [NUM_W-1:0] det_full;

   always_comb begin
      valid_in = {valid_ff[NSTAGE-2:0], in_valid};

      g1_in.u1x = in_coord.u1x;
      g1_in.u1y = in_coord.u1y;
      g1_in.u2x = in_coord.u2x;
      g1_in.u2y = in_coord.u2y;
      g1_in.wx  = DELTA_W'(in_coord.p1x) - DELTA_W'(in_coord.p2x);
      g1_in.wy  = DELTA_W'(in_coord.p1y) - DELTA_W'(in_coord.p2y);

      uu_in[0] = g1_ff.u1x * g1_ff.u1x;
      uu_in[1] = g1_ff.u1y * g1_ff.u1y;
      uu_in[2] = g1_ff.u1x * g1_ff.u2x;
      uu_in[3] = g1_ff.u1y * g1_ff.u2y;
      uu_in[4] = g1_ff.u2x * g1_ff.u2x;
      uu_in[5] = g1_ff.u2y * g1_ff.u2y;
      uw_in[0] = g1_ff.u1x * g1_ff.wx;
      uw_in[1] = g1_ff.u1y * g1_ff.wy;
      uw_in[2] = g1_ff.u2x * g1_ff.wx;
      uw_in[3] = g1_ff.u2y * g1_ff.wy;

      a3_in = UU_W'(uu_ff[0]) + UU_W'(uu_ff[1]);
      b3_in = UW_W'(uu_ff[2]) + UW_W'(uu_ff[3]);
      c3_in = UU_W'(uu_ff[4]) + UU_W'(uu_ff[5]);
      d3_in = DE_W'(uw_ff[0]) + DE_W'(uw_ff[1]);
      e3_in = DE_W'(uw_ff[2]) + DE_W'(uw_ff[3]);

      acp_in = split_mul(MUL_W'(a3_ff), MUL_W'(c3_ff));
      bbp_in = split_mul(MUL_W'(b3_ff), MUL_W'(b3_ff));
      bep_in = split_mul(MUL_W'(b3_ff), e3_ff);
      cdp_in = split_mul(MUL_W'(c3_ff), d3_ff);
      aep_in = split_mul(MUL_W'(a3_ff), e3_ff);
      bdp_in = split_mul(MUL_W'(b3_ff), d3_ff);
      tp_in = SUM_W'(e3_ff) + SUM_W'(b3_ff);
      tm_in = SUM_W'(e3_ff) - SUM_W'(b3_ff);
      sp_in = SUM_W'(b3_ff) - SUM_W'(d3_ff);
      sm_in = -SUM_W'(b3_ff) - SUM_W'(d3_ff);

      ac_in = join_parts(acp_ff);
      bb_in = join_parts(bbp_ff);
      be_in = join_parts(bep_ff);
      cd_in = join_parts(cdp_ff);
      ae_in = join_parts(aep_ff);
      bd_in = join_parts(bdp_ff);

      det_full       = ac_ff - bb_ff;
      req6_in.det    = det_full[DET_W-1:0];
      req6_in.s_num  = be_ff - cd_ff;
      req6_in.t_num  = ae_ff - bd_ff;
      req6_in.tp_num = tp5_ff;
      req6_in.tm_num = tm5_ff;
      req6_in.sp_num = sp5_ff;
      req6_in.sm_num = sm5_ff;
      req6_in.a      = a5_ff;
      req6_in.c      = c5_ff;
      side6_in.parallel = (req6_in.det == '0) ||
                          (req6_in.det < {threshold, {THR_SHIFT{1'b0}}});
      side6_in.d_neg = dneg5_ff;
      side6_in.geom  = g5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff    <= g1_in;
         g2_ff    <= g1_ff;
         g3_ff    <= g2_ff;
         g4_ff    <= g3_ff;
         g5_ff    <= g4_ff;
         uu_ff    <= uu_in;
         uw_ff    <= uw_in;
         a3_ff    <= a3_in;
         b3_ff    <= b3_in;
         c3_ff    <= c3_in;
         d3_ff    <= d3_in;
         e3_ff    <= e3_in;
         a4_ff    <= a3_ff;
         c4_ff    <= c3_ff;
         a5_ff    <= a4_ff;
         c5_ff    <= c4_ff;
         dneg4_ff <= d3_ff[DE_W-1];
         dneg5_ff <= dneg4_ff;
         acp_ff   <= acp_in;
         bbp_ff   <= bbp_in;
         bep_ff   <= bep_in;
         cdp_ff   <= cdp_in;
         aep_ff   <= aep_in;
         bdp_ff   <= bdp_in;
         ac_ff    <= ac_in;
         bb_ff    <= bb_in;
         be_ff    <= be_in;
         cd_ff    <= cd_in;
         ae_ff    <= ae_in;
         bd_ff    <= bd_in;
         tp_ff    <= tp_in;
         tm_ff    <= tm_in;
         sp_ff    <= sp_in;
         sm_ff    <= sm_in;
         tp5_ff   <= tp_ff;
         tm5_ff   <= tm_ff;
         sp5_ff   <= sp_ff;
         sm5_ff   <= sm_ff;
         req6_ff  <= req6_in;
         side6_ff <= side6_in;
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_req   = req6_ff;
   assign out_side  = side6_ff;

endmodule

// File: rtl/core/spdsq_div.sv
// spdsq_div: pipelined restoring divider, one quotient bit per stage, truncated
// toward zero, saturated at plus or minus two, and zero for a zero divisor. Depends on spdsq_pkg.
module spdsq_div (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [spdsq_pkg::NUM_W-1:0]   num,
   input  logic [spdsq_pkg::DET_W-1:0]          den,
   output logic signed [spdsq_pkg::QUOT_W-1:0]  quot
);
   import spdsq_pkg::*;

   logic [REM_W-1:0]     rem_ff [DIV_STEPS+1];
   logic [REM_W-1:0]     rem_in [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_in   [DIV_STEPS+1];
   logic [DET_W-1:0]     den_ff [DIV_STEPS+1];
   logic [DET_W-1:0]     den_in [DIV_STEPS+1];
   logic [DIV_STEPS:0]   neg_ff, neg_in, zero_ff, zero_in, sat_ff, sat_in;
   logic signed [QUOT_W-1:0] quot_ff, quot_in;

   always_comb begin
      logic [NUM_W-1:0]         mag;
      logic [REM_W-1:0]         trial;
      logic signed [QUOT_W-1:0] mag_q;

      mag        = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_in[0]  = REM_W'(mag) << PARAM_FRAC;
      q_in[0]    = '0;
      den_in[0]  = den;
      neg_in[0]  = num[NUM_W-1];
      zero_in[0] = (den == '0);
      sat_in[0]  = ({1'b0, mag} >= {den, 1'b0});

      for (int k = 0; k < DIV_STEPS; k++) begin
         trial        = REM_W'(den_ff[k]) << (DIV_STEPS - 1 - k);
         rem_in[k+1]  = rem_ff[k];
         q_in[k+1]    = q_ff[k];
         if (rem_ff[k] >= trial) begin
            rem_in[k+1] = rem_ff[k] - trial;
            q_in[k+1][DIV_STEPS-1-k] = 1'b1;
         end
         den_in[k+1]  = den_ff[k];
         neg_in[k+1]  = neg_ff[k];
         zero_in[k+1] = zero_ff[k];
         sat_in[k+1]  = sat_ff[k];
      end

      mag_q = sat_ff[DIV_STEPS] ? QUOT_W'(1 << DIV_STEPS) : QUOT_W'(q_ff[DIV_STEPS]);
      if (zero_ff[DIV_STEPS]) begin
         quot_in = '0;
      end else if (neg_ff[DIV_STEPS]) begin
         quot_in = -mag_q;
      end else begin
         quot_in = mag_q;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         den_ff  <= den_in;
         neg_ff  <= neg_in;
         zero_ff <= zero_in;
         sat_ff  <= sat_in;
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// File: rtl/core/spdsq_dist.sv
// spdsq_dist: aligns the side data with the divider outputs, picks and clamps
// both parameters and forms the saturated squared distance. Depends on spdsq_pkg.
module spdsq_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  spdsq_pkg::side_type  in_side,
   input  spdsq_pkg::quot_type  in_quot,
   output logic                 out_valid,
   output spdsq_pkg::result_type out_result
);
   import spdsq_pkg::*;

   localparam int NSTAGE = 6;

   logic [DIV_LAT-1:0] dv_ff, dv_in;
   side_type           side_ff [DIV_LAT];
   side_type           side_in [DIV_LAT];
   logic [NSTAGE-1:0]  valid_ff, valid_in;

   logic signed [PARAM_W-1:0] sc_ff [1:NSTAGE];
   logic signed [PARAM_W-1:0] tc_ff [1:NSTAGE];
   logic signed [PARAM_W-1:0] sc1_in, tc1_in;
   geom_type                  g1_ff;
   logic signed [DELTA_W-1:0] wx2_ff, wy2_ff;
   logic signed [PROD_W-1:0]  psx_ff, psx_in, psy_ff, psy_in, ptx_ff, ptx_in, pty_ff, pty_in;
   logic signed [DX_W-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   part_type                  sqxp_ff, sqxp_in, sqyp_ff, sqyp_in;
   logic signed [SQ_W-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [DIST_W-1:0]         dsq_ff, dsq_in;

   always_comb begin
      logic signed [QUOT_W-1:0] sc, tc;
      logic [SQ_W-1:0]          dd;
      side_type                 s;

      dv_in      = {dv_ff[DIV_LAT-2:0], in_valid};
      side_in[0] = in_side;
      for (int j = 1; j < DIV_LAT; j++) begin
         side_in[j] = side_ff[j-1];
      end
      valid_in = {valid_ff[NSTAGE-2:0], dv_ff[DIV_LAT-1]};

      s = side_ff[DIV_LAT-1];
      if (s.parallel) begin
         sc = s.d_neg ? -Q_PONE : Q_PONE;
         tc = s.d_neg ? in_quot.t_minus : in_quot.t_plus;
      end else if (out_of_range(in_quot.s_free)) begin
         sc = clamp_unit(in_quot.s_free);
         tc = in_quot.s_free[QUOT_W-1] ? in_quot.t_minus : in_quot.t_plus;
      end else begin
         sc = in_quot.s_free;
         tc = in_quot.t_free;
      end
      if (out_of_range(tc)) begin
         sc = clamp_unit(tc[QUOT_W-1] ? in_quot.s_minus : in_quot.s_plus);
         tc = clamp_unit(tc);
      end
      sc1_in = PARAM_W'(sc);
      tc1_in = PARAM_W'(tc);

      psx_in = sc_ff[1] * g1_ff.u1x;
      psy_in = sc_ff[1] * g1_ff.u1y;
      ptx_in = tc_ff[1] * g1_ff.u2x;
      pty_in = tc_ff[1] * g1_ff.u2y;

      dx_in = (DX_W'(wx2_ff) <<< PARAM_FRAC) + DX_W'(psx_ff) - DX_W'(ptx_ff);
      dy_in = (DX_W'(wy2_ff) <<< PARAM_FRAC) + DX_W'(psy_ff) - DX_W'(pty_ff);

      sqxp_in = split_mul(MUL_W'(dx_ff), MUL_W'(dx_ff));
      sqyp_in = split_mul(MUL_W'(dy_ff), MUL_W'(dy_ff));

      sqx_in = SQ_W'(join_parts(sqxp_ff));
      sqy_in = SQ_W'(join_parts(sqyp_ff));

      dd = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
      if (|dd[SQ_W-1:SAT_BIT]) begin
         dsq_in = '1;
      end else begin
         dsq_in = dd[SAT_BIT-1:2*COORD_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff    <= '0;
         valid_ff <= '0;
      end else if (en) begin
         dv_ff    <= dv_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= side_in;
         sc_ff[1] <= sc1_in;
         tc_ff[1] <= tc1_in;
         for (int j = 2; j <= NSTAGE; j++) begin
            sc_ff[j] <= sc_ff[j-1];
            tc_ff[j] <= tc_ff[j-1];
         end
         g1_ff   <= side_ff[DIV_LAT-1].geom;
         wx2_ff  <= g1_ff.wx;
         wy2_ff  <= g1_ff.wy;
         psx_ff  <= psx_in;
         psy_ff  <= psy_in;
         ptx_ff  <= ptx_in;
         pty_ff  <= pty_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         sqxp_ff <= sqxp_in;
         sqyp_ff <= sqyp_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         dsq_ff  <= dsq_in;
      end
   end

   assign out_valid                   = valid_ff[NSTAGE-1];
   assign out_result.distance_squared = dsq_ff;
   assign out_result.param_first      = sc_ff[NSTAGE];
   assign out_result.param_second     = tc_ff[NSTAGE];

endmodule

// File: rtl/core/segment_pair_distance_squared_unit.sv
// The unit takes one item per cycle whenever the pipeline is not stalled.
// The six 17-step pipelined dividers set the depth; all stages advance together and
// stop only when the two-entry result buffer is full and the consumer holds tready low.
// Reset (synchronous, active high) empties the pipeline and the result buffer and loads
// the parallel threshold with its default. Top level; depends on spdsq_pkg,
// spdsq_dot, spdsq_div and spdsq_dist.
module segment_pair_distance_squared_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // first_center_x, first_center_y, first_dir_x, first_dir_y,
   // second_center_x, second_center_y, second_dir_x, second_dir_y
   input  logic [spdsq_pkg::IN_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // distance_squared, param_first, param_second, zero fill
   output logic [spdsq_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [spdsq_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [spdsq_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [spdsq_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                  csr_pready
);
   import spdsq_pkg::*;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                en;
   coord_set_type       coord;
   logic                dot_valid;
   div_req_type         dot_req;
   side_type            dot_side;
   quot_type            quot;
   logic                res_valid;
   result_type          res;

   logic [1:0]  count_ff, count_in;
   result_type  slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic        push, pop;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == CSR_THRESH_IDX) ? CSR_DW'(thresh_ff) : '0;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[CSR_AW-1:2] == CSR_THRESH_IDX) begin
         thresh_in = csr_pwdata[THRESH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_W'(THRESH_RESET);
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   assign coord.p1x = req_tdata[0*COORD_W +: COORD_W];
   assign coord.p1y = req_tdata[1*COORD_W +: COORD_W];
   assign coord.u1x = req_tdata[2*COORD_W +: COORD_W];
   assign coord.u1y = req_tdata[3*COORD_W +: COORD_W];
   assign coord.p2x = req_tdata[4*COORD_W +: COORD_W];
   assign coord.p2y = req_tdata[5*COORD_W +: COORD_W];
   assign coord.u2x = req_tdata[6*COORD_W +: COORD_W];
   assign coord.u2y = req_tdata[7*COORD_W +: COORD_W];

   assign en         = !res_valid || (count_ff != 2'd2) || rsp_tready;
   assign req_tready = en;

   spdsq_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_coord  (coord),
      .threshold (thresh_ff),
      .out_valid (dot_valid),
      .out_req   (dot_req),
      .out_side  (dot_side)
   );

   spdsq_div u_div_s (
      .clock (clock), .en (en), .num (dot_req.s_num), .den (dot_req.det),
      .quot  (quot.s_free)
   );
   spdsq_div u_div_t (
      .clock (clock), .en (en), .num (dot_req.t_num), .den (dot_req.det),
      .quot  (quot.t_free)
   );
   spdsq_div u_div_tp (
      .clock (clock), .en (en), .num (NUM_W'(dot_req.tp_num)), .den (DET_W'(dot_req.c)),
      .quot  (quot.t_plus)
   );
   spdsq_div u_div_tm (
      .clock (clock), .en (en), .num (NUM_W'(dot_req.tm_num)), .den (DET_W'(dot_req.c)),
      .quot  (quot.t_minus)
   );
   spdsq_div u_div_sp (
      .clock (clock), .en (en), .num (NUM_W'(dot_req.sp_num)), .den (DET_W'(dot_req.a)),
      .quot  (quot.s_plus)
   );
   spdsq_div u_div_sm (
      .clock (clock), .en (en), .num (NUM_W'(dot_req.sm_num)), .den (DET_W'(dot_req.a)),
      .quot  (quot.s_minus)
   );

   spdsq_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (dot_valid),
      .in_side    (dot_side),
      .in_quot    (quot),
      .out_valid  (res_valid),
      .out_result (res)
   );

   assign push = res_valid && en;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = res;
            end else begin
               slot1_in = res;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = res;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = res;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = OUT_DATA_W'(slot0_ff);

endmodule

// File: rtl/core/spdsq_checker.sv
// spdsq_checker: port-level assertions for the segment pair distance unit and
// the bind that attaches them to the top level. Depends on spdsq_pkg.
module spdsq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [spdsq_pkg::IN_DATA_W-1:0]       req_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [spdsq_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   input logic                                  csr_psel,
   input logic                                  csr_penable,
   input logic                                  csr_pwrite,
   input logic [spdsq_pkg::CSR_AW-1:0]          csr_paddr,
   input logic [spdsq_pkg::CSR_DW-1:0]          csr_pwdata,
   input logic [spdsq_pkg::CSR_DW-1:0]          csr_prdata,
   input logic                                  csr_pready
);
   import spdsq_pkg::*;

   logic signed [PARAM_W-1:0] pf, ps;
   assign pf = rsp_tdata[DIST_W +: PARAM_W];
   assign ps = rsp_tdata[DIST_W+PARAM_W +: PARAM_W];

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result item changed");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item present after reset");

   a_first_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pf <= 18'sd65536) && (pf >= -18'sd65536))
      else $error("first parameter outside the unit interval");

   a_second_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ps <= 18'sd65536) && (ps >= -18'sd65536))
      else $error("second parameter outside the unit interval");

endmodule

bind segment_pair_distance_squared_unit spdsq_checker u_spdsq_checker (.*);

// File: tb/tb_segment_pair_distance_squared_unit.sv
// Self-checking testbench for segment_pair_distance_squared_unit: random and directed
// segment pairs with an exact wide-integer predictor. Depends on spdsq_pkg and the RTL.
`timescale 1ns / 100ps
module tb_segment_pair_distance_squared_unit;
   import spdsq_pkg::*;

   typedef logic signed [255:0] wide_t;
   typedef logic [IN_DATA_W-1:0] pair_t;

   typedef struct {
      logic [DIST_W-1:0]         dist_sq;
      logic signed [PARAM_W-1:0] s_param;
      logic signed [PARAM_W-1:0] t_param;
   } closest_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // first_center_x, first_center_y, first_dir_x, first_dir_y,
   // second_center_x, second_center_y, second_dir_x, second_dir_y
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // distance_squared, param_first, param_second, zero fill
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   pair_t    pending_pairs[$];
   closest_t expected_results[$];
   logic [THRESH_W-1:0] threshold = THRESH_RESET;
   int  mismatches = 0;
   bit  item_taken = 1'b0;
   bit  no_gaps = 1'b0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;

   segment_pair_distance_squared_unit u_top (.*);

   always #2 clock = ~clock;

   function automatic int quotient(wide_t num, wide_t den);
      logic [255:0] an, ad, q;
      int r;
      if (den == 0) return 0;
      an = num[255] ? -num : num;
      ad = den[255] ? -den : den;
      q = an / ad;
      r = (q >= 256'(1 << 17)) ? (1 << 17) : int'(q[17:0]);
      return (num[255] ^ den[255]) ? -r : r;
   endfunction

   function automatic int clamp_param(int v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic closest_t closest_points(pair_t pair, logic [THRESH_W-1:0] thr);
      wide_t f[8];
      wide_t wx, wy, a, b, c, d, e, det, dx, dy, dd, thr_w;
      int sc, tc;
      closest_t r;
      for (int i = 0; i < 8; i++) f[i] = $signed(pair[32*i +: 32]);
      wx = f[0] - f[4];
      wy = f[1] - f[5];
      a = f[2] * f[2] + f[3] * f[3];
      b = f[2] * f[6] + f[3] * f[7];
      c = f[6] * f[6] + f[7] * f[7];
      d = f[2] * wx + f[3] * wy;
      e = f[6] * wx + f[7] * wy;
      det = a * c - b * b;
      thr_w = {224'b0, thr};
      if (det == 0 || (det <<< 32) < (thr_w <<< 64)) begin
         sc = d[255] ? -65536 : 65536;
         tc = quotient((e <<< 16) + wide_t'(sc) * b, c);
      end else begin
         sc = quotient((b * e - c * d) <<< 16, det);
         if (sc < -65536 || sc > 65536) begin
            sc = clamp_param(sc);
            tc = quotient((e <<< 16) + wide_t'(sc) * b, c);
         end else begin
            tc = quotient((a * e - b * d) <<< 16, det);
         end
      end
      if (tc < -65536 || tc > 65536) begin
         tc = clamp_param(tc);
         sc = clamp_param(quotient(wide_t'(tc) * b - (d <<< 16), a));
      end
      dx = (wx <<< 16) + wide_t'(sc) * f[2] - wide_t'(tc) * f[6];
      dy = (wy <<< 16) + wide_t'(sc) * f[3] - wide_t'(tc) * f[7];
      dd = dx * dx + dy * dy;
      if (dd >= (wide_t'(1) <<< 95)) r.dist_sq = '1;
      else r.dist_sq = dd[94:32];
      r.s_param = sc[PARAM_W-1:0];
      r.t_param = tc[PARAM_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // Sender: a new item is put out only once the previous one has been taken.
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || item_taken)) begin
         if (pending_pairs.size() > 0 && (no_gaps || $urandom_range(99) >= 9)) begin
            req_tdata <= pending_pairs.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served < hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_gaps || $urandom_range(99) >= 9;
      end
   end

   always @(posedge clock) begin
      closest_t want;
      item_taken = req_tvalid && req_tready && !reset;
      if (item_taken) expected_results.push_back(closest_points(req_tdata, threshold));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[62:0] !== want.dist_sq)
               report_mismatch("distance_squared", rsp_tdata[62:0], want.dist_sq);
            if ($signed(rsp_tdata[80:63]) !== want.s_param)
               report_mismatch("param_first", $signed(rsp_tdata[80:63]), want.s_param);
            if ($signed(rsp_tdata[98:81]) !== want.t_param)
               report_mismatch("param_second", $signed(rsp_tdata[98:81]), want.t_param);
         end
      end
   end

   function automatic logic [31:0] near_coord();
      return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
   endfunction

   function automatic pair_t make_pair(logic [31:0] v[8]);
      pair_t p;
      for (int i = 0; i < 8; i++) p[32*i +: 32] = v[i];
      return p;
   endfunction

   function automatic pair_t random_pair();
      logic [31:0] v[8];
      int kind;
      kind = $urandom_range(9);
      for (int i = 0; i < 8; i++) v[i] = (kind == 0) ? $urandom() : near_coord();
      if (kind == 1) begin
         v[6] = v[2];
         v[7] = v[3];
      end else if (kind == 2) begin
         v[6] = -v[2] + 32'($urandom_range(3));
         v[7] = -v[3];
      end else if (kind == 3) begin
         v[2 + 4 * $urandom_range(1)] = '0;
         v[3 + 4 * $urandom_range(1)] = '0;
      end else if (kind == 4) begin
         v[4] = v[0] + 32'($urandom_range(0, 1 << 12));
         v[5] = v[1] - 32'($urandom_range(0, 1 << 12));
      end
      return make_pair(v);
   endfunction

   task automatic write_threshold(logic [THRESH_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_THRESH_IDX, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      threshold = value;
   endtask

   task automatic drain();
      while (pending_pairs.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      logic [31:0] v[8];
      logic [31:0] special[4];
      logic [THRESH_W-1:0] settings[4];
      special = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      foreach (special[k]) begin
         foreach (v[i]) v[i] = special[k];
         pending_pairs.push_back(make_pair(v));
      end
      v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0100, 32'h0, 32'h8000_0000,
            32'h8000_0000, 32'h0, 32'h0000_0100};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0005_0000, 32'h0, 32'h0001_0000, 32'h0};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0001_0000};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0004_0000, 32'h0, 32'h0, 32'h0};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0,
            32'hFFFF_0000, 32'h0001_0000};
      pending_pairs.push_back(make_pair(v));
      v = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_0001};
      pending_pairs.push_back(make_pair(v));
      v = '{32'hFFF0_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0};
      pending_pairs.push_back(make_pair(v));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      drain();
      settings = '{32'h0, 32'hFFFF_FFFF, $urandom(), THRESH_RESET};
      foreach (settings[p]) begin
         write_threshold(settings[p]);
         no_gaps = (p == 2);
         if (p == 1) hold_requests++;
         repeat (125) pending_pairs.push_back(random_pair());
         drain();
      end
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("simulation failed");
      $finish;
   end
endmodule
